>>> design/node_id_relabel_table_defines.svh
// ----------------------------------------------------------------------------
// node_id_relabel_table_defines
// assertion macros for the relabel table, empty in synthesis
// ----------------------------------------------------------------------------
`ifndef NODE_ID_RELABEL_TABLE_DEFINES_SVH
`define NODE_ID_RELABEL_TABLE_DEFINES_SVH
`ifndef SYNTHESIS
// same-cycle implication
`define NRT_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);
// next-cycle implication
`define NRT_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);
`else
`define NRT_ASSERT_NOW(lbl, ante, cons, msg)
`define NRT_ASSERT_NEXT(lbl, ante, cons, msg)
`endif
`endif

>>> design/nrt_pkg.sv
// ----------------------------------------------------------------------------
// nrt_pkg
// types and constants shared by the relabel table files
// ----------------------------------------------------------------------------
package nrt_pkg;

  localparam int MAX_LOCAL_IDS_DEF = 4096;
  localparam int TABLE_SLOTS_DEF   = 8192;

  localparam int FUNC_W  = 2;
  localparam int NODE_W  = 48;
  localparam int BATCH_W = 16;
  localparam int KEY_W   = 64;
  localparam int ID_W    = 12;
  localparam int ENTRY_W = 1 + KEY_W + ID_W;

  localparam int CFG_IDX_W  = 8;
  localparam int CFG_DATA_W = 8;

  localparam logic [FUNC_W-1:0] FN_SEED  = 2'd0;
  localparam logic [FUNC_W-1:0] FN_NEIGH = 2'd1;
  localparam logic [FUNC_W-1:0] FN_EOS   = 2'd2;
  localparam logic [FUNC_W-1:0] FN_CLEAR = 2'd3;

  localparam logic [CFG_IDX_W-1:0] CFG_DISJOINT = 8'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SWAP     = 8'd1;

  localparam logic [31:0] HASH_MULT_LO = 32'h7F4A7C15;
  localparam logic [31:0] HASH_MULT_HI = 32'h9E3779B9;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_H0,
    ST_H1,
    ST_H2,
    ST_H3,
    ST_PROBE,
    ST_CHECK
  } state_t;

  typedef struct packed {
    logic             valid;
    logic [KEY_W-1:0] key;
    logic [ID_W-1:0]  id;
  } entry_t;

endpackage

>>> design/nrt_if.sv
// ----------------------------------------------------------------------------
// nrt_if
// valid/ready channels of the relabel table
// ----------------------------------------------------------------------------
interface nrt_in_if;
  logic                         valid;
  logic                         ready;
  logic [nrt_pkg::FUNC_W-1:0]   func;
  logic [nrt_pkg::NODE_W-1:0]   node_id;
  logic [nrt_pkg::BATCH_W-1:0]  batch_id;
  modport source (output valid, func, node_id, batch_id, input ready);
  modport sink   (input valid, func, node_id, batch_id, output ready);
endinterface

interface nrt_out_if;
  logic                      valid;
  logic                      ready;
  logic [nrt_pkg::ID_W-1:0]  edge_first;
  logic [nrt_pkg::ID_W-1:0]  edge_second;
  logic                      was_new;
  logic                      overflow;
  modport source (output valid, edge_first, edge_second, was_new, overflow, input ready);
  modport sink   (input valid, edge_first, edge_second, was_new, overflow, output ready);
endinterface

interface nrt_cfg_if;
  logic                            valid;
  logic                            ready;
  logic [nrt_pkg::CFG_IDX_W-1:0]   index;
  logic [nrt_pkg::CFG_DATA_W-1:0]  data;
  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

>>> design/nrt_ram.sv
// ----------------------------------------------------------------------------
// nrt_ram
// generic single-clock ram, one write port, one registered read port
// ----------------------------------------------------------------------------
module nrt_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

>>> design/node_id_relabel_table.sv
// ----------------------------------------------------------------------------
// node_id_relabel_table
// hashed global-to-local node id relabeling with linear probing
// ----------------------------------------------------------------------------
// Keys live in one slot ram (valid, key, local id) with a registered read.
// A seed or neighbor item is accepted in the idle state, hashes the key in
// states H0 to H3 on one shared 32x32 multiplier, then passes a read and a
// compare state per probed slot. It holds the block until its probe resolves
// and, when it has a result, until the output register is free.
// An end-of-source item only advances the row. After reset and after each
// clear item the block sweeps every ram slot and takes no item meanwhile.
// TABLE_SLOTS must be a power of two of at most 2^32.
// ----------------------------------------------------------------------------
`include "node_id_relabel_table_defines.svh"

module node_id_relabel_table #(
  parameter int MAX_LOCAL_IDS = nrt_pkg::MAX_LOCAL_IDS_DEF,
  parameter int TABLE_SLOTS   = nrt_pkg::TABLE_SLOTS_DEF
) (
  input  logic      clk,
  input  logic      rst_n,
  nrt_in_if.sink    in_ch,
  nrt_out_if.source out_ch,
  nrt_cfg_if.sink   cfg_ch
);

  localparam int AW = $clog2(TABLE_SLOTS);
  localparam int NW = $clog2(MAX_LOCAL_IDS + 1);
  localparam logic [AW-1:0] LAST_SLOT = AW'(TABLE_SLOTS - 1);
  localparam logic [NW-1:0] MAX_ID    = NW'(MAX_LOCAL_IDS);

  nrt_pkg::state_t state_r, state_nxt;

  logic                        disjoint_r, swap_r;
  logic [nrt_pkg::FUNC_W-1:0]  func_r;
  logic [nrt_pkg::KEY_W-1:0]   key_r;
  logic [63:0]                 prod_r, prod_nxt;
  logic [31:0]                 acc_r, acc_nxt;
  logic [AW-1:0]               pos_r, pos_nxt;
  logic [AW-1:0]               cnt_r, cnt_nxt;
  logic [NW-1:0]               nid_r, nid_nxt;
  logic [nrt_pkg::ID_W-1:0]    row_r, row_nxt;

  logic                        out_valid_r, out_valid_nxt;
  logic [nrt_pkg::ID_W-1:0]    first_r, first_nxt, second_r, second_nxt;
  logic                        new_r, new_nxt, ovf_r, ovf_nxt;

  logic                        ram_we, ram_re;
  logic [AW-1:0]               ram_waddr;
  nrt_pkg::entry_t             ram_wdata, ram_rdata;

  logic                        in_acc, out_free;
  logic                        empty, hit, resolved, ins, ovf, need_out, done;
  logic [31:0]                 mul_a, mul_b;
  logic [nrt_pkg::ID_W-1:0]    res_id;

  nrt_ram #(
    .WIDTH (nrt_pkg::ENTRY_W),
    .DEPTH (TABLE_SLOTS)
  ) u_slots (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (pos_r),
    .rdata (ram_rdata)
  );

  assign in_ch.ready  = (state_r == nrt_pkg::ST_IDLE);
  assign in_acc       = in_ch.valid && in_ch.ready;
  assign out_free     = !out_valid_r || out_ch.ready;
  assign cfg_ch.ready = 1'b1;

  assign out_ch.valid       = out_valid_r;
  assign out_ch.edge_first  = first_r;
  assign out_ch.edge_second = second_r;
  assign out_ch.was_new     = new_r;
  assign out_ch.overflow    = ovf_r;

  // probe resolution
  assign empty    = !ram_rdata.valid;
  assign hit      = ram_rdata.valid && (ram_rdata.key == key_r);
  assign ins      = empty && (nid_r < MAX_ID);
  assign ovf      = (empty && !(nid_r < MAX_ID)) || (!empty && !hit && cnt_r == LAST_SLOT);
  assign resolved = empty || hit || ovf;
  assign need_out = (func_r == nrt_pkg::FN_NEIGH) || ovf;
  assign done     = (state_r == nrt_pkg::ST_CHECK) && resolved && (!need_out || out_free);
  assign res_id   = ins ? nid_r[nrt_pkg::ID_W-1:0] : (hit ? ram_rdata.id : '0);

  // shared multiplier: low 64-bit product bits 32 and up, from three partials
  always_comb begin
    mul_a = key_r[31:0];
    mul_b = nrt_pkg::HASH_MULT_LO;
    case (state_r)
      nrt_pkg::ST_H1: begin
        mul_a = key_r[63:32];
      end
      nrt_pkg::ST_H2: begin
        mul_b = nrt_pkg::HASH_MULT_HI;
      end
      default: begin
      end
    endcase
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      nrt_pkg::ST_CLEAR: begin
        if (pos_r == LAST_SLOT) state_nxt = nrt_pkg::ST_IDLE;
      end
      nrt_pkg::ST_IDLE: begin
        if (in_acc) begin
          case (in_ch.func)
            nrt_pkg::FN_EOS:   state_nxt = nrt_pkg::ST_IDLE;
            nrt_pkg::FN_CLEAR: state_nxt = nrt_pkg::ST_CLEAR;
            default:           state_nxt = nrt_pkg::ST_H0;
          endcase
        end
      end
      nrt_pkg::ST_H0:    state_nxt = nrt_pkg::ST_H1;
      nrt_pkg::ST_H1:    state_nxt = nrt_pkg::ST_H2;
      nrt_pkg::ST_H2:    state_nxt = nrt_pkg::ST_H3;
      nrt_pkg::ST_H3:    state_nxt = nrt_pkg::ST_PROBE;
      nrt_pkg::ST_PROBE: state_nxt = nrt_pkg::ST_CHECK;
      nrt_pkg::ST_CHECK: begin
        if (done) begin
          state_nxt = nrt_pkg::ST_IDLE;
        end else if (!resolved) begin
          state_nxt = nrt_pkg::ST_PROBE;
        end
      end
      default: state_nxt = nrt_pkg::ST_IDLE;
    endcase
  end

  // datapath and outputs
  always_comb begin
    prod_nxt      = mul_a * mul_b;
    acc_nxt       = acc_r;
    pos_nxt       = pos_r;
    cnt_nxt       = cnt_r;
    nid_nxt       = nid_r;
    row_nxt       = row_r;
    out_valid_nxt = out_valid_r && !out_ch.ready;
    first_nxt     = first_r;
    second_nxt    = second_r;
    new_nxt       = new_r;
    ovf_nxt       = ovf_r;
    ram_we        = 1'b0;
    ram_re        = 1'b0;
    ram_waddr     = pos_r;
    ram_wdata     = '{valid: 1'b1, key: key_r, id: nid_r[nrt_pkg::ID_W-1:0]};
    case (state_r)
      nrt_pkg::ST_CLEAR: begin
        ram_we          = 1'b1;
        ram_wdata.valid = 1'b0;
        pos_nxt         = pos_r + 1'b1;
      end
      nrt_pkg::ST_IDLE: begin
        pos_nxt = '0;
        if (in_acc && in_ch.func == nrt_pkg::FN_EOS) begin
          row_nxt = row_r + 1'b1;
        end
        if (in_acc && in_ch.func == nrt_pkg::FN_CLEAR) begin
          nid_nxt = '0;
          row_nxt = '0;
        end
      end
      nrt_pkg::ST_H1: begin
        acc_nxt = prod_r[63:32];
      end
      nrt_pkg::ST_H2: begin
        acc_nxt = acc_r + prod_r[31:0];
      end
      nrt_pkg::ST_H3: begin
        acc_nxt = acc_r + prod_r[31:0];
        pos_nxt = acc_nxt[AW-1:0];
        cnt_nxt = '0;
      end
      nrt_pkg::ST_PROBE: begin
        ram_re = 1'b1;
      end
      nrt_pkg::ST_CHECK: begin
        if (!resolved) begin
          pos_nxt = pos_r + 1'b1;
          cnt_nxt = cnt_r + 1'b1;
        end
        if (done) begin
          ram_we = ins;
          if (ins) nid_nxt = nid_r + 1'b1;
          if (need_out) begin
            out_valid_nxt = 1'b1;
            new_nxt       = ins;
            ovf_nxt       = ovf;
            if (func_r == nrt_pkg::FN_SEED) begin
              first_nxt  = '0;
              second_nxt = '0;
            end else if (swap_r) begin
              first_nxt  = res_id;
              second_nxt = row_r;
            end else begin
              first_nxt  = row_r;
              second_nxt = res_id;
            end
          end
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= nrt_pkg::ST_CLEAR;
      pos_r       <= '0;
      nid_r       <= '0;
      row_r       <= '0;
      out_valid_r <= 1'b0;
      disjoint_r  <= 1'b0;
      swap_r      <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      pos_r       <= pos_nxt;
      nid_r       <= nid_nxt;
      row_r       <= row_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_ch.valid && cfg_ch.index == nrt_pkg::CFG_DISJOINT) disjoint_r <= cfg_ch.data[0];
      if (cfg_ch.valid && cfg_ch.index == nrt_pkg::CFG_SWAP) swap_r <= cfg_ch.data[0];
    end
  end

  always_ff @(posedge clk) begin
    prod_r   <= prod_nxt;
    acc_r    <= acc_nxt;
    cnt_r    <= cnt_nxt;
    first_r  <= first_nxt;
    second_r <= second_nxt;
    new_r    <= new_nxt;
    ovf_r    <= ovf_nxt;
    if (in_acc) begin
      func_r <= in_ch.func;
      key_r  <= disjoint_r ? {in_ch.batch_id, in_ch.node_id}
                           : {{nrt_pkg::BATCH_W{1'b0}}, in_ch.node_id};
    end
  end

  `NRT_ASSERT_NOW(a_nid_bound, 1'b1, nid_r <= MAX_ID, "local id counter past limit")
  `NRT_ASSERT_NOW(a_we_state, ram_we, state_r == nrt_pkg::ST_CLEAR || state_r == nrt_pkg::ST_CHECK, "slot write outside check or clear")
  `NRT_ASSERT_NEXT(a_ins_count, done && ins, nid_r == $past(nid_r) + 1'b1, "insert did not advance local id")
  `NRT_ASSERT_NEXT(a_emit, done && need_out, out_valid_r, "resolved item lost its result")

endmodule

>>> sim/tb_node_id_relabel_table.sv
// ----------------------------------------------------------------------------
// tb_node_id_relabel_table
// self-checking bench for the node id relabel table
// ----------------------------------------------------------------------------
// Drives seed, neighbor, end-of-source and clear items through the valid/ready
// channels. A shadow hash table predicts every edge, and the bench compares
// each edge in order. Register settings change between phases. Both sides
// idle at random, and one long receiver hold-off backs the block up.
// ----------------------------------------------------------------------------
typedef struct packed {
  logic [nrt_pkg::ID_W-1:0] first;
  logic [nrt_pkg::ID_W-1:0] second;
  logic                     was_new;
  logic                     overflow;
} relabel_edge_t;

class relabel_scoreboard;
  localparam int SLOTS = nrt_pkg::TABLE_SLOTS_DEF;
  localparam int MAX_IDS = nrt_pkg::MAX_LOCAL_IDS_DEF;

  logic [nrt_pkg::KEY_W-1:0] slot_key[SLOTS];
  logic [nrt_pkg::ID_W-1:0]  slot_id[SLOTS];
  bit                        slot_used[SLOTS];
  int                        next_id;
  logic [nrt_pkg::ID_W-1:0]  row;
  bit                        disjoint;
  bit                        swap;
  relabel_edge_t             edges_due[$];
  int                        errors;
  int                        mismatches;

  function new();
    foreach (slot_used[i]) slot_used[i] = 0;
    next_id = 0;
    row = '0;
    disjoint = 0;
    swap = 0;
    errors = 0;
    mismatches = 0;
  endfunction

  function void set_reg(logic [nrt_pkg::CFG_IDX_W-1:0] idx,
                        logic [nrt_pkg::CFG_DATA_W-1:0] data);
    if (idx == nrt_pkg::CFG_DISJOINT) disjoint = data[0];
    else if (idx == nrt_pkg::CFG_SWAP) swap = data[0];
  endfunction

  function void empty_table();
    foreach (slot_used[i]) slot_used[i] = 0;
    next_id = 0;
    row = '0;
  endfunction

  // 0 hit, 1 inserted, 2 overflow
  function int find_or_add(logic [nrt_pkg::KEY_W-1:0] key,
                           output logic [nrt_pkg::ID_W-1:0] id);
    logic [63:0] h;
    int pos;
    h = key * {nrt_pkg::HASH_MULT_HI, nrt_pkg::HASH_MULT_LO};
    pos = int'(h[63:32] % SLOTS);
    id = '0;
    for (int n = 0; n < SLOTS; n++) begin
      if (!slot_used[pos]) begin
        if (next_id >= MAX_IDS) return 2;
        slot_used[pos] = 1;
        slot_key[pos] = key;
        slot_id[pos] = next_id[nrt_pkg::ID_W-1:0];
        id = next_id[nrt_pkg::ID_W-1:0];
        next_id++;
        return 1;
      end
      if (slot_key[pos] == key) begin
        id = slot_id[pos];
        return 0;
      end
      pos = (pos + 1) % SLOTS;
    end
    return 2;
  endfunction

  function void note_item(logic [nrt_pkg::FUNC_W-1:0] func,
                          logic [nrt_pkg::NODE_W-1:0] node,
                          logic [nrt_pkg::BATCH_W-1:0] batch);
    logic [nrt_pkg::KEY_W-1:0] key;
    logic [nrt_pkg::ID_W-1:0] id;
    relabel_edge_t e;
    int r;
    if (func == nrt_pkg::FN_EOS) begin
      row = row + 1'b1;
      return;
    end
    if (func == nrt_pkg::FN_CLEAR) begin
      empty_table();
      return;
    end
    key = disjoint ? {batch, node} : {16'h0, node};
    r = find_or_add(key, id);
    if (func == nrt_pkg::FN_SEED) begin
      if (r == 2) begin
        e = '{first: '0, second: '0, was_new: 1'b0, overflow: 1'b1};
        edges_due = {edges_due, e};
      end
      return;
    end
    if (r == 2) id = '0;
    e.first = swap ? id : row;
    e.second = swap ? row : id;
    e.was_new = (r == 1);
    e.overflow = (r == 2);
    edges_due = {edges_due, e};
  endfunction

  function void check_edge(relabel_edge_t got);
    relabel_edge_t exp_e;
    if (edges_due.size() == 0) begin
      errors++;
      mismatches++;
      if (mismatches <= 10)
        $display("unexpected edge: first=%0d second=%0d new=%0b ovf=%0b",
                 got.first, got.second, got.was_new, got.overflow);
      return;
    end
    exp_e = edges_due.pop_front();
    if (got !== exp_e) begin
      errors++;
      mismatches++;
      if (mismatches <= 10)
        $display("edge mismatch: exp %0d/%0d new=%0b ovf=%0b got %0d/%0d new=%0b ovf=%0b",
                 exp_e.first, exp_e.second, exp_e.was_new, exp_e.overflow,
                 got.first, got.second, got.was_new, got.overflow);
    end
  endfunction

  function int pending();
    return edges_due.size();
  endfunction
endclass

module tb_node_id_relabel_table;
  timeunit 1ns;
  timeprecision 1ps;

  logic clk;
  logic rst_n;

  nrt_in_if  in_ch();
  nrt_out_if out_ch();
  nrt_cfg_if cfg_ch();

  node_id_relabel_table dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .cfg_ch (cfg_ch)
  );

  relabel_scoreboard sb;
  int send_idle_pct;
  int recv_idle_pct;
  int hold_cycles;
  logic [nrt_pkg::NODE_W-1:0] node_pool[32];

  initial clk = 1'b0;
  always #6 clk = ~clk;

  initial begin
    #40ms;
    $display("node_id_relabel_table verification failed");
    $finish;
  end

  // receiver: random stalls plus one long hold-off
  always @(negedge clk) begin
    if (hold_cycles > 0) begin
      hold_cycles <= hold_cycles - 1;
      out_ch.ready <= 1'b0;
    end else begin
      out_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  always @(posedge clk) begin
    if (rst_n && in_ch.valid && in_ch.ready)
      sb.note_item(in_ch.func, in_ch.node_id, in_ch.batch_id);
    if (rst_n && cfg_ch.valid && cfg_ch.ready)
      sb.set_reg(cfg_ch.index, cfg_ch.data);
    if (rst_n && out_ch.valid && out_ch.ready)
      sb.check_edge('{first: out_ch.edge_first, second: out_ch.edge_second,
                      was_new: out_ch.was_new, overflow: out_ch.overflow});
  end

  // called at a falling edge, returns at a falling edge
  task automatic send_item(logic [nrt_pkg::FUNC_W-1:0] func,
                           logic [nrt_pkg::NODE_W-1:0] node,
                           logic [nrt_pkg::BATCH_W-1:0] batch);
    while ($urandom_range(99) < send_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(negedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.func <= func;
    in_ch.node_id <= node;
    in_ch.batch_id <= batch;
    do @(posedge clk); while (!in_ch.ready);
    @(negedge clk);
  endtask

  task automatic write_reg(logic [nrt_pkg::CFG_IDX_W-1:0] idx,
                           logic [nrt_pkg::CFG_DATA_W-1:0] data);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data <= data;
    do @(posedge clk); while (!cfg_ch.ready);
    @(negedge clk);
    cfg_ch.valid <= 1'b0;
  endtask

  // wait for every edge, then until the block is idle again
  task automatic drain();
    in_ch.valid <= 1'b0;
    while (sb.pending() > 0) @(negedge clk);
    repeat (40) @(negedge clk);
    while (!in_ch.ready) @(negedge clk);
  endtask

  function automatic logic [nrt_pkg::NODE_W-1:0] pick_node();
    if ($urandom_range(99) < 70) return node_pool[$urandom_range(31)];
    return nrt_pkg::NODE_W'({$urandom, $urandom});
  endfunction

  function automatic logic [nrt_pkg::BATCH_W-1:0] pick_batch();
    if ($urandom_range(99) < 80) return nrt_pkg::BATCH_W'($urandom_range(3));
    return nrt_pkg::BATCH_W'($urandom);
  endfunction

  task automatic random_items(int count);
    int r;
    for (int i = 0; i < count; i++) begin
      r = $urandom_range(999);
      if (r < 4) send_item(nrt_pkg::FN_CLEAR, pick_node(), pick_batch());
      else if (r < 90) send_item(nrt_pkg::FN_EOS, pick_node(), pick_batch());
      else if (r < 260) send_item(nrt_pkg::FN_SEED, pick_node(), pick_batch());
      else send_item(nrt_pkg::FN_NEIGH, pick_node(), pick_batch());
    end
  endtask

  initial begin
    sb = new();
    rst_n = 1'b0;
    in_ch.valid = 1'b0;
    in_ch.func = nrt_pkg::FN_SEED;
    in_ch.node_id = '0;
    in_ch.batch_id = '0;
    cfg_ch.valid = 1'b0;
    cfg_ch.index = nrt_pkg::CFG_DISJOINT;
    cfg_ch.data = '0;
    out_ch.ready = 1'b0;
    hold_cycles = 0;
    send_idle_pct = 0;
    recv_idle_pct = 0;
    node_pool[0] = '0;
    node_pool[1] = '1;
    for (int i = 2; i < 32; i++) node_pool[i] = nrt_pkg::NODE_W'({$urandom, $urandom});
    repeat (11) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // directed: seeds, duplicates, hits, new keys, row advance, clear
    send_item(nrt_pkg::FN_SEED, '0, 16'h0000);
    send_item(nrt_pkg::FN_SEED, '1, 16'hffff);
    send_item(nrt_pkg::FN_SEED, '0, 16'h0001);
    send_item(nrt_pkg::FN_NEIGH, '0, 16'h0000);
    send_item(nrt_pkg::FN_NEIGH, '1, 16'h0000);
    send_item(nrt_pkg::FN_NEIGH, 48'h5555_aaaa_5555, 16'haaaa);
    send_item(nrt_pkg::FN_NEIGH, 48'h5555_aaaa_5555, 16'h5555);
    send_item(nrt_pkg::FN_EOS, '0, '0);
    send_item(nrt_pkg::FN_NEIGH, 48'haaaa_5555_aaaa, 16'h5555);
    send_item(nrt_pkg::FN_NEIGH, '0, 16'hffff);
    send_item(nrt_pkg::FN_CLEAR, '0, '0);
    send_item(nrt_pkg::FN_NEIGH, '1, 16'h1234);
    drain();
    write_reg(nrt_pkg::CFG_DISJOINT, 8'd1);
    write_reg(nrt_pkg::CFG_SWAP, 8'd1);
    // old keys stay as formed across the mode change
    send_item(nrt_pkg::FN_NEIGH, '1, 16'h0000);
    send_item(nrt_pkg::FN_SEED, '1, 16'hffff);
    send_item(nrt_pkg::FN_NEIGH, '1, 16'hffff);
    send_item(nrt_pkg::FN_NEIGH, '1, 16'h0001);
    send_item(nrt_pkg::FN_EOS, '0, '0);
    send_item(nrt_pkg::FN_NEIGH, '0, 16'h0001);
    drain();

    // phase one: sender idles little, receiver a lot
    send_idle_pct = 17;
    recv_idle_pct = 63;
    random_items(300);
    hold_cycles = 400;
    for (int i = 0; i < 40; i++) send_item(nrt_pkg::FN_NEIGH, pick_node(), pick_batch());
    random_items(300);
    drain();
    write_reg(nrt_pkg::CFG_DISJOINT, 8'd0);
    write_reg(nrt_pkg::CFG_SWAP, 8'd1);

    // phase two: reversed
    send_idle_pct = 63;
    recv_idle_pct = 17;
    random_items(300);
    drain();
    random_items(300);
    drain();
    write_reg(nrt_pkg::CFG_DISJOINT, 8'd1);
    write_reg(nrt_pkg::CFG_SWAP, 8'd0);

    // phase three: no idling
    send_idle_pct = 0;
    recv_idle_pct = 0;
    random_items(250);
    send_item(nrt_pkg::FN_CLEAR, '0, '0);
    send_item(nrt_pkg::FN_NEIGH, 48'h0002_0000_0000, 16'hbeef);
    send_item(nrt_pkg::FN_NEIGH, '1, 16'hbeef);
    random_items(250);
    drain();
    write_reg(nrt_pkg::CFG_DISJOINT, 8'd0);
    write_reg(nrt_pkg::CFG_SWAP, 8'd0);
    random_items(100);

    drain();
    repeat (40) @(posedge clk);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("node_id_relabel_table verification clean");
    end else begin
      $display("node_id_relabel_table verification failed");
    end
    $finish;
  end
endmodule

>>> sim.f
+incdir+design
design/nrt_pkg.sv
design/nrt_if.sv
design/nrt_ram.sv
design/node_id_relabel_table.sv
sim/tb_node_id_relabel_table.sv
